// File: hdl/pdt_pkg.sv
// Shared constants, types and helper functions of the particle deposition terrain block.
`default_nettype none
package pdt_pkg;
   localparam int DIM_BITS    = 8;
   localparam int MAX_DIM     = 256;
   localparam int HEIGHT_BITS = 16;
   localparam int ADDR_BITS   = 2 * DIM_BITS;
   localparam int COORD_BITS  = DIM_BITS + 2;
   localparam int PASS_BITS   = 9;
   localparam int MAX_RADIUS  = 15;
   localparam logic [HEIGHT_BITS-1:0] LFSR_TAPS = 16'hB400;

   localparam logic [1:0] KIND_RESTART = 2'd0;
   localparam logic [1:0] KIND_STEP    = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;

   localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
   localparam logic [2:0] REG_GRID_LENGTH = 3'd1;
   localparam logic [2:0] REG_RADIUS      = 3'd2;
   localparam logic [2:0] REG_THRESHOLD   = 3'd3;
   localparam logic [2:0] REG_PARTICLE    = 3'd4;
   localparam logic [2:0] REG_START_X     = 3'd5;
   localparam logic [2:0] REG_START_Y     = 3'd6;
   localparam logic [2:0] REG_SEED        = 3'd7;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [HEIGHT_BITS-1:0] height_type;

   // walker step offsets
   function automatic coord_type step_dx(input logic [2:0] d);
      coord_type v;
      case (d)
         3'd0, 3'd3, 3'd5: v = -COORD_BITS'(1);
         3'd2, 3'd4, 3'd7: v = COORD_BITS'(1);
         default:          v = '0;
      endcase
      return v;
   endfunction

   function automatic coord_type step_dy(input logic [2:0] d);
      coord_type v;
      case (d)
         3'd0, 3'd1, 3'd2: v = COORD_BITS'(1);
         3'd5, 3'd6, 3'd7: v = -COORD_BITS'(1);
         default:          v = '0;
      endcase
      return v;
   endfunction

   // spiral directions: up, right, down, left
   function automatic coord_type spiral_dx(input logic [1:0] d);
      coord_type v;
      case (d)
         2'd1:    v = COORD_BITS'(1);
         2'd3:    v = -COORD_BITS'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic coord_type spiral_dy(input logic [1:0] d);
      coord_type v;
      case (d)
         2'd0:    v = -COORD_BITS'(1);
         2'd2:    v = COORD_BITS'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic height_type lfsr_next(input height_type l);
      return {1'b0, l[HEIGHT_BITS-1:1]} ^ (l[0] ? LFSR_TAPS : '0);
   endfunction
endpackage
`default_nettype wire

// File: hdl/pdt_height_ram.sv
// Height grid memory: single port, synchronous read; the read data is registered.
`default_nettype none
module pdt_height_ram (
   input  wire logic                          clock,
   input  wire logic                          we,
   input  wire logic [pdt_pkg::ADDR_BITS-1:0] addr,
   input  wire pdt_pkg::height_type           wdata,
   output pdt_pkg::height_type                rdata
);
   pdt_pkg::height_type mem [2**pdt_pkg::ADDR_BITS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// File: hdl/particle_deposition_terrain_top.sv
// Particle deposition terrain block: control, settings and result register.
//
// Requests come in on req_ (tuser = kind, tdata = direction/read_x/read_y) and each
// request gives exactly one result on rsp_ (tuser = dropped, tdata = positions and
// heights). Settings are written through csr_we/csr_index/csr_wdata while idle.
// After reset the height grid is cleared, one cell a cycle, while req_tready stays
// low (settings writes are taken throughout). Restart and unused kinds go from
// idle straight to the result state; an in-range read passes through S_RD first.
// A step first reads the target cell, then runs up to 512 search passes: each pass
// starts in S_PASS, steps through the spiral positions in S_WALK, and reads and
// compares each position on the grid within the radius in S_CMP; landing writes
// the new height to the cell in S_LAND.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls and a second result is ready, the block holds it and
// takes no further request until the register frees.
`default_nettype none
module particle_deposition_terrain_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // kind
   input  wire logic [23:0] req_tdata,   // direction[2:0], read_x[10:3], read_y[18:11]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [0:0]       rsp_tuser,   // dropped
   output logic [63:0]      rsp_tdata,   // drop_x, drop_y, drop_height, cell_height, peak
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_RD    = 9'b000000100,
      S_START = 9'b000001000,
      S_PASS  = 9'b000010000,
      S_WALK  = 9'b000100000,
      S_CMP   = 9'b001000000,
      S_LAND  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // settings
   logic [8:0]  width_ff, length_ff;
   logic [3:0]  radius_ff;
   pdt_pkg::height_type thr_ff, part_ff, seed_ff;
   logic [7:0]  sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256; length_ff <= 9'd256; radius_ff <= 4'd4;
         thr_ff <= 16'd1; part_ff <= 16'd1; sx_ff <= '0; sy_ff <= '0; seed_ff <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            pdt_pkg::REG_GRID_WIDTH:  width_ff  <= csr_wdata[8:0];
            pdt_pkg::REG_GRID_LENGTH: length_ff <= csr_wdata[8:0];
            pdt_pkg::REG_RADIUS:      radius_ff <= csr_wdata[3:0];
            pdt_pkg::REG_THRESHOLD:   thr_ff    <= csr_wdata;
            pdt_pkg::REG_PARTICLE:    part_ff   <= csr_wdata;
            pdt_pkg::REG_START_X:     sx_ff     <= csr_wdata[7:0];
            pdt_pkg::REG_START_Y:     sy_ff     <= csr_wdata[7:0];
            pdt_pkg::REG_SEED:        seed_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped grid size and radius
   logic [8:0] w_eff, l_eff;
   logic [3:0] r_eff;
   logic [7:0] r_sq;
   logic [4:0] last_seg;
   assign w_eff = (width_ff == '0) ? 9'd1 : ((width_ff > 9'd256) ? 9'd256 : width_ff);
   assign l_eff = (length_ff == '0) ? 9'd1 : ((length_ff > 9'd256) ? 9'd256 : length_ff);
   assign r_eff = (radius_ff == '0) ? 4'd1 : radius_ff;
   assign r_sq = r_eff * r_eff;
   assign last_seg = {r_eff, 1'b1};

   // walker, search and result state
   logic [7:0] wx_ff, wx_in, wy_ff, wy_in;
   pdt_pkg::height_type lfsr_ff, lfsr_in, peak_ff, peak_in, cz_ff, cz_in;
   pdt_pkg::coord_type cx_ff, cx_in, cy_ff, cy_in, ox_ff, ox_in, oy_ff, oy_in;
   pdt_pkg::coord_type px_ff, px_in, py_ff, py_in;
   logic [1:0] dir_ff, dir_in;
   logic [4:0] seg_ff, seg_in, idx_ff, idx_in;
   logic       odd_ff, odd_in;
   logic [pdt_pkg::PASS_BITS-1:0] pass_ff, pass_in;
   logic [pdt_pkg::ADDR_BITS-1:0] clr_ff, clr_in;
   logic        res_drop_ff, res_drop_in;
   logic [7:0]  res_x_ff, res_x_in, res_y_ff, res_y_in;
   pdt_pkg::height_type res_h_ff, res_h_in, res_cell_ff, res_cell_in, res_pk_ff, res_pk_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [64:0] rsp_data_ff, rsp_data_in;

   // memory port
   logic mem_we;
   logic [pdt_pkg::ADDR_BITS-1:0] mem_addr;
   pdt_pkg::height_type mem_wdata, mem_rdata;

   pdt_height_ram u_ram (
      .clock (clock), .we (mem_we), .addr (mem_addr), .wdata (mem_wdata), .rdata (mem_rdata)
   );

   // request fields
   logic [1:0] kind;
   logic [2:0] sdir;
   logic [7:0] rx, ry;
   assign kind = req_tuser;
   assign sdir = req_tdata[2:0];
   assign rx   = req_tdata[10:3];
   assign ry   = req_tdata[18:11];

   logic accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   // step target
   pdt_pkg::coord_type tx, ty;
   logic t_on;
   assign tx = pdt_pkg::coord_type'({2'b00, wx_ff}) + pdt_pkg::step_dx(sdir);
   assign ty = pdt_pkg::coord_type'({2'b00, wy_ff}) + pdt_pkg::step_dy(sdir);
   assign t_on = !tx[pdt_pkg::COORD_BITS-1] && (tx < $signed({1'b0, w_eff}))
              && !ty[pdt_pkg::COORD_BITS-1] && (ty < $signed({1'b0, l_eff}));

   // next spiral position and its eligibility
   pdt_pkg::coord_type nx, ny, ddx, ddy, adx, ady;
   logic n_on, n_near;
   logic [8:0] dsq;
   assign nx = px_ff + pdt_pkg::spiral_dx(dir_ff);
   assign ny = py_ff + pdt_pkg::spiral_dy(dir_ff);
   assign n_on = !nx[pdt_pkg::COORD_BITS-1] && (nx < $signed({1'b0, w_eff}))
              && !ny[pdt_pkg::COORD_BITS-1] && (ny < $signed({1'b0, l_eff}));
   assign ddx = nx - ox_ff;
   assign ddy = ny - oy_ff;
   assign adx = ddx[pdt_pkg::COORD_BITS-1] ? -ddx : ddx;
   assign ady = ddy[pdt_pkg::COORD_BITS-1] ? -ddy : ddy;
   assign dsq = 9'(adx[3:0] * adx[3:0]) + 9'(ady[3:0] * ady[3:0]);
   assign n_near = (adx < pdt_pkg::coord_type'(16)) && (ady < pdt_pkg::coord_type'(16))
                && (dsq < {1'b0, r_sq});

   // slide test and landing sum
   logic slide;
   logic [16:0] land_sum;
   pdt_pkg::height_type land_h;
   assign slide = ({1'b0, mem_rdata} + {1'b0, thr_ff}) <= {1'b0, cz_ff};
   assign land_sum = {1'b0, cz_ff} + {1'b0, part_ff};
   assign land_h = land_sum[16] ? '1 : land_sum[15:0];

   pdt_pkg::height_type lfsr_adv;
   assign lfsr_adv = pdt_pkg::lfsr_next(lfsr_ff);

   // main sequencer
   always_comb begin
      state_in = state_ff;
      wx_in = wx_ff; wy_in = wy_ff; lfsr_in = lfsr_ff; peak_in = peak_ff; cz_in = cz_ff;
      cx_in = cx_ff; cy_in = cy_ff; ox_in = ox_ff; oy_in = oy_ff; px_in = px_ff; py_in = py_ff;
      dir_in = dir_ff; seg_in = seg_ff; idx_in = idx_ff; odd_in = odd_ff; pass_in = pass_ff;
      clr_in = clr_ff;
      res_drop_in = res_drop_ff; res_x_in = res_x_ff; res_y_in = res_y_ff;
      res_h_in = res_h_ff; res_cell_in = res_cell_ff; res_pk_in = res_pk_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      mem_we = 1'b0; mem_addr = {py_ff[7:0], px_ff[7:0]}; mem_wdata = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               res_drop_in = 1'b0; res_x_in = '0; res_y_in = '0;
               res_h_in = '0; res_cell_in = '0; res_pk_in = peak_ff;
               state_in = S_DONE;
               case (kind)
                  pdt_pkg::KIND_RESTART: begin
                     wx_in = sx_ff; wy_in = sy_ff;
                     lfsr_in = (seed_ff == '0) ? 16'd1 : seed_ff;
                  end
                  pdt_pkg::KIND_STEP: begin
                     mem_addr = {ty[7:0], tx[7:0]};
                     if (t_on) begin
                        wx_in = tx[7:0]; wy_in = ty[7:0];
                        cx_in = tx; cy_in = ty;
                        state_in = S_START;
                     end
                  end
                  pdt_pkg::KIND_READ: begin
                     mem_addr = {ry, rx};
                     if ({1'b0, rx} < w_eff && {1'b0, ry} < l_eff) begin
                        state_in = S_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            res_cell_in = mem_rdata;
            state_in = S_DONE;
         end
         S_START: begin
            cz_in = mem_rdata;
            pass_in = '0;
            state_in = S_PASS;
         end
         S_PASS: begin
            lfsr_in = lfsr_adv;
            dir_in = lfsr_adv[1:0] + 2'd1;
            ox_in = cx_ff; oy_in = cy_ff; px_in = cx_ff; py_in = cy_ff;
            seg_in = 5'd1; idx_in = '0; odd_in = 1'b0;
            state_in = S_WALK;
         end
         S_WALK, S_CMP: begin
            logic seg_end;
            seg_end = 1'b0;
            if (state_ff == S_WALK) begin
               px_in = nx; py_in = ny;
               mem_addr = {ny[7:0], nx[7:0]};
               if (n_on && n_near) begin
                  state_in = S_CMP;
               end else begin
                  seg_end = (idx_ff + 1'b1 == seg_ff);
               end
            end else begin
               state_in = S_WALK;
               if (slide) begin
                  cx_in = px_ff; cy_in = py_ff; cz_in = mem_rdata;
                  seg_end = 1'b1;
               end else begin
                  seg_end = (idx_ff + 1'b1 == seg_ff);
               end
            end
            if (state_in == S_WALK) begin
               if (!seg_end) begin
                  idx_in = idx_ff + 1'b1;
               end else if (seg_ff == last_seg) begin
                  // spiral done: settle or run another pass
                  if ((cx_in == ox_ff && cy_in == oy_ff) || pass_ff == '1) begin
                     state_in = S_LAND;
                  end else begin
                     pass_in = pass_ff + 1'b1;
                     state_in = S_PASS;
                  end
               end else begin
                  idx_in = '0;
                  dir_in = dir_ff + 2'd1;
                  odd_in = !odd_ff;
                  if (odd_ff) begin
                     seg_in = seg_ff + 1'b1;
                  end
               end
            end
         end
         S_LAND: begin
            mem_we = 1'b1;
            mem_addr = {cy_ff[7:0], cx_ff[7:0]};
            mem_wdata = land_h;
            peak_in = (land_h > peak_ff) ? land_h : peak_ff;
            res_drop_in = 1'b1; res_x_in = cx_ff[7:0]; res_y_in = cy_ff[7:0];
            res_h_in = land_h; res_pk_in = peak_in;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {res_pk_ff, res_cell_ff, res_h_ff, res_y_ff, res_x_ff, res_drop_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; rsp_valid_ff <= 1'b0;
         wx_ff <= '0; wy_ff <= '0; peak_ff <= '0; lfsr_ff <= 16'd1;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; rsp_valid_ff <= rsp_valid_in;
         wx_ff <= wx_in; wy_ff <= wy_in; peak_ff <= peak_in; lfsr_ff <= lfsr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cz_ff <= cz_in; cx_ff <= cx_in; cy_ff <= cy_in; ox_ff <= ox_in; oy_ff <= oy_in;
      px_ff <= px_in; py_ff <= py_in; dir_ff <= dir_in; seg_ff <= seg_in; idx_ff <= idx_in;
      odd_ff <= odd_in; pass_ff <= pass_in;
      res_drop_ff <= res_drop_in; res_x_ff <= res_x_in; res_y_ff <= res_y_in;
      res_h_ff <= res_h_in; res_cell_ff <= res_cell_in; res_pk_ff <= res_pk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff[0:0];
   assign rsp_tdata  = rsp_data_ff[64:1];

`ifndef SYNTHESIS
   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_LAND))
      else $error("grid written outside clear or landing");
   a_cmp_after_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> $past(state_ff) == S_WALK)
      else $error("compare without a preceding read");
   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PASS |-> lfsr_ff != '0)
      else $error("search LFSR stuck at zero");
`endif
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench of the particle deposition terrain block.
`default_nettype none
module testbench;
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] dir;
      logic [7:0] rx;
      logic [7:0] ry;
   } request_type;

   // laid out as {rsp_tuser, rsp_tdata}, highest field first
   typedef struct packed {
      logic        dropped;
      logic [15:0] pk;
      logic [15:0] ch;
      logic [15:0] dh;
      logic [7:0]  dy;
      logic [7:0]  dx;
   } outcome_type;

   localparam int WATCHDOG_LIMIT = 4000000;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [0:0]  rsp_tuser;
   logic [63:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   particle_deposition_terrain_top u_top (.*);

   // terrain model state
   logic [15:0] terrain [0:65535];
   int          walk_x, walk_y;
   logic [15:0] top_height;
   logic [15:0] shift_reg;
   logic [8:0]  cfg_width, cfg_length;
   logic [3:0]  cfg_radius;
   logic [15:0] cfg_thresh, cfg_part, cfg_seed;
   logic [7:0]  cfg_sx, cfg_sy;

   request_type pending_requests [$];
   outcome_type expected_outcomes [$];
   int       failures = 0;
   int       drops_seen = 0, results_seen = 0;
   int       idle_cycles = 0;
   bit       long_hold = 0;
   bit       stall_go = 0;
   bit       stall_done = 0;

   function automatic int clamp_to(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int ofs_dx(int d);
      case (d)
         0, 3, 5: return -1;
         2, 4, 7: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic int ofs_dy(int d);
      case (d)
         0, 1, 2: return 1;
         5, 6, 7: return -1;
         default: return 0;
      endcase
   endfunction

   // repeated spiral searches until the particle rests
   task automatic slide_particle(inout int cx, inout int cy, input int w, input int l);
      int r, ox, oy, px, py, seg, ddx, ddy;
      int dir;
      int turns;
      logic [16:0] cz, h;
      r = clamp_to(cfg_radius, pdt_pkg::MAX_RADIUS);
      cz = terrain[cy*256+cx];
      for (int pass = 0; pass < 512; pass++) begin
         shift_reg = {1'b0, shift_reg[15:1]} ^ (shift_reg[0] ? 16'hB400 : 16'h0);
         dir = shift_reg[1:0];
         ox = cx; oy = cy; px = cx; py = cy; seg = 0; turns = 0;
         while (seg <= 2*r) begin
            dir = (dir + 1) & 3;
            if ((turns & 1) == 0) seg++;
            for (int i = 0; i < seg; i++) begin
               px += (dir == 1) ? 1 : (dir == 3) ? -1 : 0;
               py += (dir == 0) ? -1 : (dir == 2) ? 1 : 0;
               if (px < 0 || px >= w || py < 0 || py >= l) continue;
               ddx = px - ox; ddy = py - oy;
               if (ddx*ddx + ddy*ddy >= r*r) continue;
               h = terrain[py*256+px];
               if (h + cfg_thresh <= cz) begin
                  cx = px; cy = py; cz = h;
                  break;
               end
            end
            turns++;
         end
         if (cx == ox && cy == oy) break;
      end
   endtask

   task automatic predict_outcome(input request_type q);
      outcome_type o;
      int w, l, tx, ty, lx, ly;
      logic [16:0] nh;
      o = '0;
      w = clamp_to(cfg_width, pdt_pkg::MAX_DIM);
      l = clamp_to(cfg_length, pdt_pkg::MAX_DIM);
      case (q.kind)
         pdt_pkg::KIND_RESTART: begin
            walk_x = cfg_sx; walk_y = cfg_sy;
            shift_reg = (cfg_seed != 0) ? cfg_seed : 16'd1;
         end
         pdt_pkg::KIND_STEP: begin
            tx = walk_x + ofs_dx(q.dir);
            ty = walk_y + ofs_dy(q.dir);
            if (tx >= 0 && tx < w && ty >= 0 && ty < l) begin
               walk_x = tx; walk_y = ty; lx = tx; ly = ty;
               slide_particle(lx, ly, w, l);
               nh = terrain[ly*256+lx] + cfg_part;
               if (nh[16]) nh = 17'h0FFFF;
               terrain[ly*256+lx] = nh[15:0];
               if (nh[15:0] > top_height) top_height = nh[15:0];
               o.dropped = 1; o.dx = lx[7:0]; o.dy = ly[7:0]; o.dh = nh[15:0];
            end
         end
         pdt_pkg::KIND_READ: begin
            if (q.rx < w && q.ry < l) o.ch = terrain[q.ry*256+q.rx];
         end
         default: ;
      endcase
      o.pk = top_height;
      expected_outcomes.push_back(o);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         pdt_pkg::REG_GRID_WIDTH:  cfg_width = v[8:0];
         pdt_pkg::REG_GRID_LENGTH: cfg_length = v[8:0];
         pdt_pkg::REG_RADIUS:      cfg_radius = v[3:0];
         pdt_pkg::REG_THRESHOLD:   cfg_thresh = v;
         pdt_pkg::REG_PARTICLE:    cfg_part = v;
         pdt_pkg::REG_START_X:     cfg_sx = v[7:0];
         pdt_pkg::REG_START_Y:     cfg_sy = v[7:0];
         pdt_pkg::REG_SEED:        cfg_seed = v;
         default: ;
      endcase
   endtask

   task automatic queue_request(input logic [1:0] k, input logic [2:0] d,
                                input logic [7:0] x, input logic [7:0] y);
      request_type q;
      q.kind = k; q.dir = d; q.rx = x; q.ry = y;
      pending_requests.push_back(q);
   endtask

   // wait until the block has drained everything queued so far
   task automatic drain_block();
      while (pending_requests.size() != 0 || expected_outcomes.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // a walk of steps with random directions, sometimes a read of a random cell, a restart or an unused kind
   task automatic queue_walk(input int n, input int wmax);
      for (int i = 0; i < n; i++) begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 70) queue_request(pdt_pkg::KIND_STEP, 3'($urandom), 8'($urandom),
                                   8'($urandom));
         else if (r < 90)
            queue_request(pdt_pkg::KIND_READ, 3'($urandom), 8'($urandom_range(0, wmax)),
                          8'($urandom_range(0, wmax)));
         else if (r < 96) queue_request(pdt_pkg::KIND_RESTART, 3'($urandom), 8'($urandom),
                                        8'($urandom));
         else queue_request(KIND_SPARE, 3'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // request driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         send_gap <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else if (send_gap > 0) begin
         req_tvalid <= 0;
         send_gap <= send_gap - 1;
      end else if (pending_requests.size() != 0) begin
         request_type q;
         q = pending_requests.pop_front();
         req_tvalid <= 1;
         req_tuser <= q.kind;
         req_tdata <= {5'd0, q.ry, q.rx, q.dir};
         predict_outcome(q);
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end else begin
         req_tvalid <= 0;
      end
   end

   // long receiver stall, counted here once requested
   initial begin
      wait (stall_go);
      @(posedge clock);
      long_hold <= 1;
      repeat (3000) @(posedge clock);
      long_hold <= 0;
      stall_done = 1;
   end

   // result monitor with random back-pressure
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            outcome_type got, exp;
            got = {rsp_tuser[0], rsp_tdata};
            results_seen++;
            if (expected_outcomes.size() == 0) begin
               $error("result with nothing expected: %h", got);
               failures++;
            end else begin
               exp = expected_outcomes.pop_front();
               if (got.dropped != exp.dropped) begin
                  $error("dropped: expected %0d, got %0d", exp.dropped, got.dropped);
                  failures++;
               end
               if (got.dx != exp.dx) begin
                  $error("drop_x: expected %0d, got %0d", exp.dx, got.dx); failures++;
               end
               if (got.dy != exp.dy) begin
                  $error("drop_y: expected %0d, got %0d", exp.dy, got.dy); failures++;
               end
               if (got.dh != exp.dh) begin
                  $error("drop_height: expected %0d, got %0d", exp.dh, got.dh);
                  failures++;
               end
               if (got.ch != exp.ch) begin
                  $error("cell_height: expected %0d, got %0d", exp.ch, got.ch);
                  failures++;
               end
               if (got.pk != exp.pk) begin
                  $error("peak_height: expected %0d, got %0d", exp.pk, got.pk);
                  failures++;
               end
               if (exp.dropped) drops_seen++;
            end
         end
         if (long_hold) begin
            rsp_tready <= 0;
            hold_left <= 0;
         end else if (hold_left > 0) begin
            rsp_tready <= 0;
            hold_left <= hold_left - 1;
         end else if (rsp_tvalid && rsp_tready || !rsp_tready) begin
            rsp_tready <= 1;
            hold_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      reset = 1;
      req_tuser = 0; req_tdata = 0;
      csr_we = 0; csr_index = pdt_pkg::REG_GRID_WIDTH; csr_wdata = 0;
      walk_x = 0; walk_y = 0; top_height = 0; shift_reg = 16'd1;
      cfg_width = 256; cfg_length = 256; cfg_radius = 4; cfg_thresh = 1;
      cfg_part = 1; cfg_sx = 0; cfg_sy = 0; cfg_seed = 1;
      for (int i = 0; i < 65536; i++) terrain[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: walker at origin, steps off the grid, reads of the corner cells, an unused kind
      queue_request(pdt_pkg::KIND_STEP, 3'd5, 8'd0, 8'd0);
      for (int d = 0; d < 8; d++) queue_request(pdt_pkg::KIND_STEP, 3'(d), 8'hFF, 8'hFF);
      queue_request(pdt_pkg::KIND_READ, 3'd0, 8'd0, 8'd0);
      queue_request(pdt_pkg::KIND_READ, 3'd7, 8'd255, 8'd255);
      queue_request(KIND_SPARE, 3'd7, 8'hFF, 8'hFF);
      drain_block();

      // small grid, zero seed, corner start, large particles to reach saturation
      write_reg(pdt_pkg::REG_GRID_WIDTH, 16'd4);
      write_reg(pdt_pkg::REG_GRID_LENGTH, 16'd4);
      write_reg(pdt_pkg::REG_RADIUS, 16'd15);
      write_reg(pdt_pkg::REG_THRESHOLD, 16'd0);
      write_reg(pdt_pkg::REG_PARTICLE, 16'hFFFF);
      write_reg(pdt_pkg::REG_START_X, 16'd3);
      write_reg(pdt_pkg::REG_START_Y, 16'd3);
      write_reg(pdt_pkg::REG_SEED, 16'd0);
      queue_request(pdt_pkg::KIND_RESTART, 3'd0, 8'd0, 8'd0);
      for (int d = 0; d < 8; d++) queue_request(pdt_pkg::KIND_STEP, 3'(d), 8'd0, 8'd0);
      queue_request(pdt_pkg::KIND_READ, 3'd0, 8'd4, 8'd1);
      queue_request(pdt_pkg::KIND_READ, 3'd0, 8'd2, 8'd2);
      drain_block();

      // clamped dimensions and radius
      write_reg(pdt_pkg::REG_GRID_WIDTH, 16'd0);
      write_reg(pdt_pkg::REG_GRID_LENGTH, 16'h1FF);
      write_reg(pdt_pkg::REG_RADIUS, 16'd0);
      write_reg(pdt_pkg::REG_PARTICLE, 16'd0);
      write_reg(pdt_pkg::REG_START_X, 16'd0);
      write_reg(pdt_pkg::REG_START_Y, 16'd255);
      write_reg(pdt_pkg::REG_SEED, 16'hFFFF);
      queue_request(pdt_pkg::KIND_RESTART, 3'd0, 8'd0, 8'd0);
      queue_walk(40, 255);
      drain_block();

      // random phases on small grids, the last one 256 cells wide
      for (int ph = 0; ph < 8; ph++) begin
         int sz;
         sz = (ph == 7) ? 256 : $urandom_range(1, 12);
         write_reg(pdt_pkg::REG_GRID_WIDTH, 16'(sz));
         write_reg(pdt_pkg::REG_GRID_LENGTH, 16'($urandom_range(1, 12)));
         write_reg(pdt_pkg::REG_RADIUS, 16'($urandom_range(1, (ph == 7) ? 2 : 6)));
         write_reg(pdt_pkg::REG_THRESHOLD,
                   16'((ph == 3) ? 16'hFFFF : $urandom_range(0, 3)));
         write_reg(pdt_pkg::REG_PARTICLE,
                   16'((ph == 4) ? 16'h8000 : $urandom_range(1, 5)));
         write_reg(pdt_pkg::REG_START_X, 16'($urandom_range(0, 11)));
         write_reg(pdt_pkg::REG_START_Y, 16'($urandom_range(0, 11)));
         write_reg(pdt_pkg::REG_SEED, 16'($urandom));
         queue_request(pdt_pkg::KIND_RESTART, 3'd0, 8'd0, 8'd0);
         queue_walk(240, 12);
         if (ph == 2) begin
            // receiver stalls while the sender keeps offering requests
            stall_go = 1;
            wait (stall_done);
         end
         drain_block();
      end
      repeat (200) @(posedge clock);
      $display("Checked %0d results: %0d particle drops, several grid and radius settings.",
               results_seen, drops_seen);
      if (failures == 0 && expected_outcomes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: particle_deposition_terrain_top.f
hdl/pdt_pkg.sv
hdl/pdt_height_ram.sv
hdl/particle_deposition_terrain_top.sv
sim/testbench.sv
